[rtl/core/agc_pkg.sv]
// Shared constants, codes and types for the accelerometer gesture classifier.
`default_nettype none

package agc_pkg;

  // Default sample width and derived fixed widths of the result fields.
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned IN_W            = 16;
  localparam int unsigned OUT_W           = 17;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CNT_W           = 17;
  localparam int unsigned ACT_W           = 3;

  // Item kinds.
  localparam logic [1:0] OP_SAMPLE   = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_CLASSIFY = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_COOLDOWN  = 1'b1;

  // Register reset values.
  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd5000;
  localparam logic [CFG_W-1:0] COOLDOWN_RESET  = 16'd1000;

  // The millisecond counter stops at this value.
  localparam logic [CNT_W-1:0] COOLDOWN_SAT = 17'd65536;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_NONE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_XPOS = 3'd1;
  localparam logic [ACT_W-1:0] ACT_XNEG = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ZPOS = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ZNEG = 3'd4;

  // Verdict of the merging stage.
  typedef struct packed {
    logic             fire;
    logic [ACT_W-1:0] action;
  } class_res_t;

  // One result beat.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             fired;
    logic [OUT_W-1:0] smooth_x;
    logic [OUT_W-1:0] smooth_y;
    logic [OUT_W-1:0] smooth_z;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/agc_axis_lane.sv]
// One axis lane: previous sample and the change filter of that axis.
`default_nettype none

module agc_axis_lane import agc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire logic                   first_i,
  input  wire logic [IN_W-1:0]        sample_i,
  output logic signed [SAMPLE_BITS:0] filt_q_o,
  output logic signed [SAMPLE_BITS:0] filt_d_o
);

  localparam int unsigned FW = SAMPLE_BITS + 1;
  localparam int unsigned SW = FW + 3;

  logic [SAMPLE_BITS+IN_W-1:0] raw_ext;
  logic signed [SAMPLE_BITS-1:0] samp;
  logic signed [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic signed [FW-1:0] filt_q, filt_d;
  logic signed [FW-1:0] diff;
  logic signed [SW-1:0] f_ext, d_ext, sum, adj;
  logic [SW-1:0] bias;

  // The low sample bits form a two's complement value.
  assign raw_ext = {{SAMPLE_BITS{1'b0}}, sample_i};
  assign samp    = $signed(raw_ext[SAMPLE_BITS-1:0]);

  // Change from the previous sample, one bit wider than a sample.
  assign diff = {prev_q[SAMPLE_BITS-1], prev_q} - {samp[SAMPLE_BITS-1], samp};

  // Smoothing (3*f + d) / 4, rounded toward zero by biasing negative sums.
  assign f_ext = {{3{filt_q[FW-1]}}, filt_q};
  assign d_ext = {{3{diff[FW-1]}}, diff};
  assign sum   = f_ext + (f_ext <<< 1) + d_ext;
  assign bias  = {{(SW-2){1'b0}}, sum[SW-1], sum[SW-1]};
  assign adj   = sum + $signed(bias);

  // A good sample always becomes the previous one; the very first clears the filter.
  always_comb begin
    prev_d = prev_q;
    filt_d = filt_q;
    if (load_i) begin
      prev_d = samp;
      filt_d = first_i ? '0 : adj[FW+1:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      filt_q <= '0;
    end else begin
      prev_q <= prev_d;
      filt_q <= filt_d;
    end
  end

  assign filt_q_o = filt_q;
  assign filt_d_o = filt_d;

endmodule

`default_nettype wire

[rtl/core/agc_classify.sv]
// Merging stage: compares the x and z lane filters and picks a gesture.
`default_nettype none

module agc_classify import agc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic signed [SAMPLE_BITS:0] filt_x_i,
  input  wire logic signed [SAMPLE_BITS:0] filt_z_i,
  input  wire logic [CFG_W-1:0]            threshold_i,
  output class_res_t                       res_o
);

  localparam int unsigned FW = SAMPLE_BITS + 1;
  localparam int unsigned CW = ((FW > CFG_W) ? FW : CFG_W) + 1;

  logic [FW-1:0] ax, az;
  logic [FW+1:0] ax3, az3;
  logic [CW-1:0] ax_c, az_c, th_c;
  logic x_dom, z_dom, x_hit, z_hit;

  // Magnitudes; the most negative value maps to its unsigned magnitude.
  assign ax = filt_x_i[FW-1] ? (~filt_x_i + 1'b1) : filt_x_i;
  assign az = filt_z_i[FW-1] ? (~filt_z_i + 1'b1) : filt_z_i;

  // Three times each magnitude; the halving is the drop of the low bit.
  assign ax3 = {2'b00, ax} + {1'b0, ax, 1'b0};
  assign az3 = {2'b00, az} + {1'b0, az, 1'b0};

  assign x_dom = {1'b0, ax} > az3[FW+1:1];
  assign z_dom = {1'b0, az} > ax3[FW+1:1];

  // Threshold compare at a common width.
  assign ax_c = {{(CW-FW){1'b0}}, ax};
  assign az_c = {{(CW-FW){1'b0}}, az};
  assign th_c = {{(CW-CFG_W){1'b0}}, threshold_i};

  assign x_hit = (ax_c > th_c) && x_dom;
  assign z_hit = (az_c > th_c) && z_dom;

  // The x axis takes priority over z.
  always_comb begin
    res_o.fire   = x_hit || z_hit;
    res_o.action = ACT_NONE;
    if (x_hit) begin
      res_o.action = filt_x_i[FW-1] ? ACT_XNEG : ACT_XPOS;
    end else if (z_hit) begin
      res_o.action = filt_z_i[FW-1] ? ACT_ZNEG : ACT_ZPOS;
    end
  end

endmodule

`default_nettype wire

[rtl/core/accel_gesture_classifier_unit.sv]
// Top level of the accelerometer gesture classifier: lanes, merge, state and result buffer.
// A result goes to the output register, or to the skid register while the output is full.
// Throughput: one item per cycle while ready; state updates in the cycle the beat is taken.
// An output register plus one skid register let an input beat be taken while a
// result still waits; input ready drops only when both hold a result.
// Reset (asynchronous, active low) clears the filters, previous samples, action and
// counter, sets the first-sample flag and loads the register defaults 5000 and 1000.
`default_nettype none

module accel_gesture_classifier_unit import agc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Configuration write port.
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_addr_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  // Input channel.
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [IN_W-1:0]  sample_x_i,
  input  wire logic [IN_W-1:0]  sample_y_i,
  input  wire logic [IN_W-1:0]  sample_z_i,
  input  wire logic             read_ok_i,
  input  wire logic             gesture_enable_i,
  // Result channel.
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ACT_W-1:0]      action_o,
  output logic                  gesture_fired_o,
  output logic [OUT_W-1:0]      smooth_x_o,
  output logic [OUT_W-1:0]      smooth_y_o,
  output logic [OUT_W-1:0]      smooth_z_o
);

  localparam int unsigned FW = SAMPLE_BITS + 1;

  logic [CFG_W-1:0] threshold_q, cooldown_ms_q;
  logic             first_q;
  logic [ACT_W-1:0] held_q, held_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept, load, fire;
  logic signed [FW-1:0] fx_q, fy_q, fz_q, fx_d, fy_d, fz_d;
  logic [FW+OUT_W-1:0] ox_ext, oy_ext, oz_ext;
  class_res_t       cls;
  result_t          res_new, out_q, skid_q;
  logic             out_valid_q, skid_valid_q, pop;

  assign accept = in_valid_i && in_ready_o;
  assign load   = accept && (op_i == OP_SAMPLE) && read_ok_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= THRESHOLD_RESET;
      cooldown_ms_q <= COOLDOWN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_THRESHOLD: threshold_q   <= cfg_wdata_i;
        CFG_COOLDOWN:  cooldown_ms_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Axis lanes.
  agc_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk_i, .rst_ni, .load_i(load), .first_i(first_q), .sample_i(sample_x_i),
    .filt_q_o(fx_q), .filt_d_o(fx_d)
  );

  agc_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk_i, .rst_ni, .load_i(load), .first_i(first_q), .sample_i(sample_y_i),
    .filt_q_o(fy_q), .filt_d_o(fy_d)
  );

  agc_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
    .clk_i, .rst_ni, .load_i(load), .first_i(first_q), .sample_i(sample_z_i),
    .filt_q_o(fz_q), .filt_d_o(fz_d)
  );

  // Merge of the x and z lanes.
  agc_classify #(.SAMPLE_BITS(SAMPLE_BITS)) u_classify (
    .filt_x_i(fx_q), .filt_z_i(fz_q), .threshold_i(threshold_q), .res_o(cls)
  );

  // A gesture fires only when enabled and the cooldown has run out.
  assign fire = accept && (op_i == OP_CLASSIFY) && gesture_enable_i &&
                (cnt_q > {1'b0, cooldown_ms_q}) && cls.fire;

  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    if (fire) begin
      held_d = cls.action;
      cnt_d  = '0;
    end else if (accept && (op_i == OP_TICK) && (cnt_q != COOLDOWN_SAT)) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      held_q  <= ACT_NONE;
      cnt_q   <= '0;
    end else begin
      if (load) begin
        first_q <= 1'b0;
      end
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

  // Filter values as 17-bit two's complement words.
  assign ox_ext = {{OUT_W{fx_d[FW-1]}}, fx_d};
  assign oy_ext = {{OUT_W{fy_d[FW-1]}}, fy_d};
  assign oz_ext = {{OUT_W{fz_d[FW-1]}}, fz_d};

  always_comb begin
    res_new.action   = held_d;
    res_new.fired    = fire;
    res_new.smooth_x = ox_ext[OUT_W-1:0];
    res_new.smooth_y = oy_ext[OUT_W-1:0];
    res_new.smooth_z = oz_ext[OUT_W-1:0];
  end

  // Output register with a skid stage behind it.
  assign pop        = out_valid_q && out_ready_i;
  assign in_ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end else if (accept) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = out_q.action;
  assign gesture_fired_o = out_q.fired;
  assign smooth_x_o      = out_q.smooth_x;
  assign smooth_y_o      = out_q.smooth_y;
  assign smooth_z_o      = out_q.smooth_z;

  // The y filter is only reported; its present value is not needed by the merge.
  logic unused_fy;
  assign unused_fy = ^fy_q;

endmodule

`default_nettype wire

[rtl/core/agc_checker.sv]
// Port-level checker for the gesture classifier and its bind to the top level.
`default_nettype none

module agc_checker import agc_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic [1:0]       op_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [ACT_W-1:0] action_o,
  input wire logic             gesture_fired_o,
  input wire logic [OUT_W-1:0] smooth_x_o
);

  // A fired beat always carries a real gesture code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && gesture_fired_o) |-> (action_o != ACT_NONE))
    else $error("gesture fired with no action");

  // Action codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (action_o <= ACT_ZNEG))
    else $error("action code out of range");

  // Input back-pressure only happens while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // A classify beat is the only one that can fire a gesture.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (op_i != OP_CLASSIFY) && !out_valid_o)
      |=> (out_valid_o && !gesture_fired_o))
    else $error("gesture fired by a non-classify beat");

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(action_o) && $stable(smooth_x_o)))
    else $error("result beat changed while stalled");

endmodule

bind accel_gesture_classifier_unit agc_checker u_agc_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o),
  .op_i(op_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .action_o(action_o),
  .gesture_fired_o(gesture_fired_o),
  .smooth_x_o(smooth_x_o)
);

`default_nettype wire
